>>> rtl/hbm_pkg.sv
// ----------------------------------------------------------------------------
// hbm_pkg: shared types and constants of the heartbeat timeout monitor
// request and response formats, action codes, register map and defaults
// ----------------------------------------------------------------------------
package hbm_pkg;

  // default sizing
  localparam int NUM_NODES_DEF  = 40;
  localparam int NUM_CARS_DEF   = 8;
  localparam int COUNT_BITS_DEF = 16;

  // frame identifiers per external car
  localparam int FUNCS_PER_CAR  = 16;
  localparam int FUNC_SHIFT     = $clog2(FUNCS_PER_CAR);

  // field widths
  localparam int ACTION_W   = 3;
  localparam int PORT_W     = 2;
  localparam int NODE_W     = 6;
  localparam int FID_W      = 11;
  localparam int TIMEOUT_W  = 16;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_TICK        = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_HEARD_LOCAL = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_HEARD_EXT   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_QUERY_LOCAL = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_QUERY_CAR   = 3'd4;

  // valid bus numbers
  localparam logic [PORT_W-1:0] BUS_A = 2'd1;
  localparam logic [PORT_W-1:0] BUS_B = 2'd2;

  // register indexes, taken from paddr[2]
  localparam logic REG_TIMEOUT  = 1'b0;
  localparam logic REG_EXT_BASE = 1'b1;

  // register reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd10;
  localparam logic [FID_W-1:0]     EXT_BASE_RST = 11'h080;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PORT_W-1:0]   bus_port;
    logic [NODE_W-1:0]   node_index;
    logic [FID_W-1:0]    function_id;
  } hbm_req_t;

  typedef struct packed {
    logic fault;
    logic bad_request;
  } hbm_rsp_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [FID_W-1:0]     external_base_id;
  } hbm_cfg_t;

endpackage

>>> rtl/hbm_cfg_regs.sv
// ----------------------------------------------------------------------------
// hbm_cfg_regs: configuration registers
// apb write and read of timeout_ticks and external_base_id
// ----------------------------------------------------------------------------
module hbm_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hbm_pkg::PADDR_W-1:0] paddr,
  input  logic [hbm_pkg::PDATA_W-1:0] pwdata,
  output logic [hbm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output hbm_pkg::hbm_cfg_t           cfg
);
  import hbm_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks    <= TIMEOUT_RST;
      cfg.external_base_id <= EXT_BASE_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_TIMEOUT:  cfg.timeout_ticks    <= pwdata[TIMEOUT_W-1:0];
        REG_EXT_BASE: cfg.external_base_id <= pwdata[FID_W-1:0];
        default:      cfg.timeout_ticks    <= cfg.timeout_ticks;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TIMEOUT:  prdata = {{(PDATA_W-TIMEOUT_W){1'b0}}, cfg.timeout_ticks};
      REG_EXT_BASE: prdata = {{(PDATA_W-FID_W){1'b0}}, cfg.external_base_id};
      default:      prdata = '0;
    endcase
  end

endmodule

>>> rtl/hbm_counter_bank.sv
// ----------------------------------------------------------------------------
// hbm_counter_bank: row of saturating silence counters
// all lanes count up on a tick, one lane clears on a heard frame
// ----------------------------------------------------------------------------
module hbm_counter_bank #(
  parameter int DEPTH      = 2 * hbm_pkg::NUM_NODES_DEF,
  parameter int COUNT_BITS = hbm_pkg::COUNT_BITS_DEF,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick,
  input  logic                  clr,
  input  logic [AW-1:0]         clr_addr,
  input  logic [AW-1:0]         rd_addr,
  output logic [COUNT_BITS-1:0] rd_data
);
  import hbm_pkg::*;

  logic [COUNT_BITS-1:0] count [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        count[i] <= '0;
      end
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (tick && (count[i] != {COUNT_BITS{1'b1}})) begin
          count[i] <= count[i] + 1'b1;
        end else if (clr && (clr_addr == AW'(i))) begin
          count[i] <= '0;
        end
      end
    end
  end

  assign rd_data = count[rd_addr];

endmodule

>>> rtl/node_heartbeat_timeout_monitor.sv
// ----------------------------------------------------------------------------
// node_heartbeat_timeout_monitor: liveness monitor for two redundant buses
// silence counters per local node and per external car, timeout queries
// ----------------------------------------------------------------------------
// The monitor takes one request every cycle unless stalled, and answers a
// query from its response register: the request lands in an input register,
// and the counter update or the counter lookup and timeout compare sit
// between that register and the response register. A tick bumps every
// counter of both buses at the same time, since each counter has its own
// saturating incrementer. Ticks and heard-frame requests give no response;
// query requests give exactly one. The input register keeps taking requests
// while a response waits, and stalls only when both it and the response
// register are full and the response is not taken. Counters come out of
// reset at zero with no clearing pass. Registers: timeout_ticks at byte
// address 0, external_base_id at 4; write them only while the block is idle.
// ----------------------------------------------------------------------------
module node_heartbeat_timeout_monitor #(
  parameter int NUM_NODES  = hbm_pkg::NUM_NODES_DEF,
  parameter int NUM_CARS   = hbm_pkg::NUM_CARS_DEF,
  parameter int COUNT_BITS = hbm_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        req_valid,
  output logic                        req_ready,
  input  hbm_pkg::hbm_req_t           req_data,
  // response channel
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output hbm_pkg::hbm_rsp_t           rsp_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hbm_pkg::PADDR_W-1:0] paddr,
  input  logic [hbm_pkg::PDATA_W-1:0] pwdata,
  output logic [hbm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import hbm_pkg::*;

  localparam int LAW  = $clog2(2 * NUM_NODES);
  localparam int CAW  = $clog2(2 * NUM_CARS);
  localparam int CMPW = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;
  localparam int CARW = FID_W - FUNC_SHIFT;

  hbm_cfg_t cfg;

  // input register
  logic     s1_valid;
  hbm_req_t s1_req;
  logic     s1_go;

  // decoded request
  logic            port_ok;
  logic            bank;
  logic            node_ok;
  logic            car_q_ok;
  logic [FID_W:0]  car_diff;
  logic [CARW-1:0] car_num;
  logic            car_hit;
  logic            is_query;
  logic            bad;
  logic            timed_out;

  // counter bank hookup
  logic                  tick;
  logic                  local_clr;
  logic                  car_clr;
  logic [LAW-1:0]        local_addr;
  logic [CAW-1:0]        car_clr_addr;
  logic [CAW-1:0]        car_rd_addr;
  logic [COUNT_BITS-1:0] local_count;
  logic [COUNT_BITS-1:0] car_count;
  logic [COUNT_BITS-1:0] sel_count;

  hbm_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the input register moves on whenever the response register can load
  assign s1_go     = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready) begin
      s1_req <= req_data;
    end
  end

  // bus decode: bus 2 selects the upper half of each bank
  assign port_ok = (s1_req.bus_port == BUS_A) || (s1_req.bus_port == BUS_B);
  assign bank    = (s1_req.bus_port == BUS_B);

  // index range checks
  assign node_ok  = {1'b0, s1_req.node_index} < (NODE_W + 1)'(NUM_NODES);
  assign car_q_ok = {1'b0, s1_req.node_index} < (NODE_W + 1)'(NUM_CARS);

  // external frame to car number: borrow out means id below the base
  assign car_diff = {1'b0, s1_req.function_id} - {1'b0, cfg.external_base_id};
  assign car_num  = car_diff[FID_W-1:FUNC_SHIFT];
  assign car_hit  = !car_diff[FID_W] && (car_num < CARW'(NUM_CARS));

  // bank addresses, only meaningful when the index is in range
  assign local_addr   = bank ? (LAW'(NUM_NODES) + LAW'(s1_req.node_index))
                             : LAW'(s1_req.node_index);
  assign car_clr_addr = bank ? (CAW'(NUM_CARS) + CAW'(car_num)) : CAW'(car_num);
  assign car_rd_addr  = bank ? (CAW'(NUM_CARS) + CAW'(s1_req.node_index))
                             : CAW'(s1_req.node_index);

  // counter updates happen when the request leaves the input register
  assign tick      = s1_valid && s1_go && (s1_req.action == ACT_TICK);
  assign local_clr = s1_valid && s1_go && (s1_req.action == ACT_HEARD_LOCAL)
                     && port_ok && node_ok;
  assign car_clr   = s1_valid && s1_go && (s1_req.action == ACT_HEARD_EXT)
                     && port_ok && car_hit;

  hbm_counter_bank #(
    .DEPTH      (2 * NUM_NODES),
    .COUNT_BITS (COUNT_BITS),
    .AW         (LAW)
  ) u_local (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick),
    .clr      (local_clr),
    .clr_addr (local_addr),
    .rd_addr  (local_addr),
    .rd_data  (local_count)
  );

  hbm_counter_bank #(
    .DEPTH      (2 * NUM_CARS),
    .COUNT_BITS (COUNT_BITS),
    .AW         (CAW)
  ) u_car (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick),
    .clr      (car_clr),
    .clr_addr (car_clr_addr),
    .rd_addr  (car_rd_addr),
    .rd_data  (car_count)
  );

  // query evaluation
  always_comb begin
    is_query  = 1'b0;
    bad       = 1'b0;
    sel_count = local_count;
    unique case (s1_req.action)
      ACT_QUERY_LOCAL: begin
        is_query  = 1'b1;
        bad       = !port_ok || !node_ok;
        sel_count = local_count;
      end
      ACT_QUERY_CAR: begin
        is_query  = 1'b1;
        bad       = !port_ok || !car_q_ok;
        sel_count = car_count;
      end
      default: begin
        is_query  = 1'b0;
      end
    endcase
  end

  // a saturated counter below a large timeout never times out
  assign timed_out = CMPW'(sel_count) >= CMPW'(cfg.timeout_ticks);

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_go) begin
      rsp_valid <= s1_valid && is_query;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      rsp_data.fault       <= bad || timed_out;
      rsp_data.bad_request <= bad;
    end
  end

endmodule

>>> rtl/hbm_checker.sv
// ----------------------------------------------------------------------------
// hbm_checker: port-level checks of the heartbeat timeout monitor
// response hold, response coding, reset and flow-through of requests
// ----------------------------------------------------------------------------
module hbm_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input hbm_pkg::hbm_rsp_t rsp_data
);
  import hbm_pkg::*;

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

  // a bad request always reports a fault
  a_bad_is_fault: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.bad_request |-> rsp_data.fault)
    else $error("bad request without fault");

  // no response right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid after reset");

  // requests flow whenever the response side is free
  a_no_false_stall: assert property (@(posedge clk)
    (rsp_ready || !rsp_valid) |-> req_ready)
    else $error("request stalled with response side free");

endmodule

bind node_heartbeat_timeout_monitor hbm_checker u_hbm_checker (.*);
